// ===== hw/rtl/lsh_pkg.sv =====
// Package with shared types and constants of the near-duplicate index.
`timescale 1ns / 1ps
package lsh_pkg;
    localparam int Dim = 16;
    localparam int MaxVectors = 1024;
    localparam int NumTables = 8;
    localparam int HashBits = 12;
    localparam int DimW = $clog2(Dim);
    localparam int VecW = $clog2(MaxVectors);
    localparam int CntW = VecW + 1;
    localparam int TabW = $clog2(NumTables);
    localparam int BitW = $clog2(HashBits);
    localparam int EpsW = 36;
    localparam int AccW = 48;

    typedef enum logic [1:0] {
        REQ_PLANE = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_CHECK = 2'd2,
        REQ_CLEAR = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_NO_MATCH = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    localparam logic [1:0] CFG_EPSILON = 2'd0;
    localparam logic [1:0] CFG_TABLES = 2'd1;
    localparam logic [1:0] CFG_BITS = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic signed [15:0] value;
        logic [2:0] plane_table;
        logic [3:0] plane_bit;
        logic [3:0] element_index;
        logic last;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] match_index;
        logic [10:0] stored_count;
    } out_item_t;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic enable;
        logic diff_mode;
    } mac_ctrl_t;
endpackage

// ===== hw/rtl/lsh_mac.sv =====
// Shared multiply-accumulate unit for dot products and squared distances.
`timescale 1ns / 1ps
module lsh_mac (
    input  logic                          aclk,
    input  lsh_pkg::mac_ctrl_t            ctrl,
    input  logic signed [15:0]            a,
    input  logic signed [15:0]            b,
    output logic signed [lsh_pkg::AccW-1:0] acc
);
    import lsh_pkg::*;

    logic signed [16:0] op_a;
    logic signed [16:0] op_b;
    logic signed [33:0] prod;
    logic signed [AccW-1:0] acc_reg;

    always_comb begin
        if (ctrl.diff_mode) begin
            op_a = 17'(a) - 17'(b);
            op_b = op_a;
        end else begin
            op_a = 17'(a);
            op_b = 17'(b);
        end
        prod = 34'(op_a) * 34'(op_b);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            acc_reg <= '0;
        end else if (ctrl.enable) begin
            acc_reg <= acc_reg + AccW'(prod);
        end
    end

    assign acc = acc_reg;
endmodule

// ===== hw/rtl/lsh_near_duplicate_index_unit.sv =====
// Top level of the locality-sensitive hashing near-duplicate index.
`timescale 1ns / 1ps
// Requests are taken one at a time. A plane element or a vector element without the last flag
// is taken while the block stays idle, ready for the next request. A clear sweeps the 32768
// bucket heads, one a cycle, and the block is also busy for that sweep after reset. An element
// with the last flag is hashed through one shared multiply-accumulate unit, table by table and
// bit by bit; then the chains of its buckets are walked table by table, with a squared distance
// computed for each stored vector visited. An insert then copies the vector and links the new
// entry into each table. The result is offered after that, and no request is taken until it
// has been accepted.
module lsh_near_duplicate_index_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lsh_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output lsh_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [35:0]        cfg_data
);
    import lsh_pkg::*;

    localparam int PlaneDepth = NumTables * HashBits * Dim;
    localparam int PlaneAw = $clog2(PlaneDepth);
    localparam int HeadAw = TabW + HashBits;
    localparam int LinkAw = VecW + TabW;
    localparam int VstAw = VecW + DimW;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH_RD, S_HASH_ACC, S_HASH_END, S_HEAD_RD, S_HEAD_WAIT,
        S_DIST_RD, S_DIST_ACC, S_DIST_END, S_LINK_RD, S_INS_WR, S_INS_RD, S_INS_LINK, S_OUT
    } state_t;

    state_t state_reg;
    logic [HeadAw-1:0] clr_addr_reg;
    logic [EpsW-1:0] eps_reg;
    logic [3:0] tabs_cfg_reg;
    logic [3:0] bits_cfg_reg;
    logic [CntW-1:0] count_reg;
    logic [1:0] req_reg;
    logic [TabW-1:0] tab_reg;
    logic [BitW-1:0] bit_reg;
    logic [DimW:0] dim_reg;
    logic [HashBits-1:0] hash_reg [NumTables];
    logic [HashBits-1:0] cur_hash_reg;
    logic [CntW-1:0] ptr_reg;
    logic [CntW-1:0] steps_reg;
    logic [1:0] out_status_reg;
    logic [VecW-1:0] out_index_reg;
    logic m_valid_reg;

    logic signed [15:0] query_mem [Dim];
    logic signed [15:0] plane_mem [PlaneDepth];
    logic signed [15:0] vec_mem [MaxVectors * Dim];
    logic [CntW-1:0] head_mem [NumTables * (2 ** HashBits)];
    logic [CntW-1:0] link_mem [MaxVectors * NumTables];
    logic signed [15:0] plane_rd_reg;
    logic signed [15:0] vec_rd_reg;
    logic signed [15:0] query_rd_reg;
    logic [CntW-1:0] head_rd_reg;
    logic [CntW-1:0] link_rd_reg;

    logic [TabW:0] ntab;
    logic [BitW:0] nbits;
    logic [DimW-1:0] dim_idx;
    logic [PlaneAw-1:0] plane_rd_addr;
    logic [HeadAw-1:0] head_addr;
    logic [VecW-1:0] idx;
    mac_ctrl_t mac_ctrl;
    logic signed [15:0] mac_b;
    logic signed [AccW-1:0] acc;
    logic s_fire;

    assign ntab = (tabs_cfg_reg == 4'd0 || tabs_cfg_reg > 4'(NumTables))
        ? (TabW + 1)'(NumTables) : (TabW + 1)'(tabs_cfg_reg);
    assign nbits = (bits_cfg_reg == 4'd0 || bits_cfg_reg > 4'(HashBits))
        ? (BitW + 1)'(HashBits) : (BitW + 1)'(bits_cfg_reg);
    assign dim_idx = dim_reg[DimW-1:0];
    assign plane_rd_addr = PlaneAw'((32'(tab_reg) * HashBits + 32'(bit_reg)) * Dim
        + 32'(dim_idx));
    assign head_addr = {tab_reg, hash_reg[tab_reg]};
    assign idx = VecW'(ptr_reg - 1'b1);
    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign cfg_ready = 1'b1;
    assign s_fire = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data.status = out_status_reg;
    assign m_data.match_index = out_index_reg;
    assign m_data.stored_count = count_reg;

    always_comb begin
        mac_ctrl.clear = (state_reg == S_HASH_RD || state_reg == S_DIST_RD) && dim_reg == '0;
        mac_ctrl.enable = (state_reg == S_HASH_ACC || state_reg == S_DIST_ACC);
        mac_ctrl.diff_mode = (state_reg == S_DIST_ACC);
        mac_b = (state_reg == S_DIST_ACC) ? vec_rd_reg : plane_rd_reg;
    end

    lsh_mac u_mac (
        .aclk (aclk),
        .ctrl (mac_ctrl),
        .a    (query_rd_reg),
        .b    (mac_b),
        .acc  (acc)
    );

    always_ff @(posedge aclk) begin
        plane_rd_reg <= plane_mem[plane_rd_addr];
        vec_rd_reg <= vec_mem[VstAw'({idx, dim_idx})];
        query_rd_reg <= query_mem[dim_idx];
        head_rd_reg <= head_mem[head_addr];
        link_rd_reg <= link_mem[LinkAw'({idx, tab_reg})];
        if (s_fire && s_data.req_type == REQ_PLANE && s_data.plane_bit < 4'(HashBits)) begin
            plane_mem[PlaneAw'((32'(s_data.plane_table) * HashBits + 32'(s_data.plane_bit))
                * Dim + 32'(s_data.element_index))] <= s_data.value;
        end
        if (s_fire && (s_data.req_type == REQ_INSERT || s_data.req_type == REQ_CHECK)) begin
            query_mem[s_data.element_index] <= s_data.value;
        end
        if (state_reg == S_CLEAR) begin
            head_mem[clr_addr_reg] <= '0;
        end else if (state_reg == S_INS_LINK) begin
            head_mem[head_addr] <= count_reg;
        end
        if (state_reg == S_INS_WR && dim_reg != '0) begin
            vec_mem[VstAw'({count_reg[VecW-1:0], DimW'(dim_reg - 1'b1)})] <= query_rd_reg;
        end
        if (state_reg == S_INS_LINK) begin
            link_mem[LinkAw'({count_reg[VecW-1:0] - 1'b1, tab_reg})] <= head_rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_addr_reg <= '0;
            eps_reg <= '0;
            tabs_cfg_reg <= 4'd8;
            bits_cfg_reg <= 4'd12;
            count_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_EPSILON: eps_reg <= cfg_data;
                    CFG_TABLES: tabs_cfg_reg <= cfg_data[3:0];
                    CFG_BITS: bits_cfg_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == '1) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    tab_reg <= '0;
                    bit_reg <= '0;
                    dim_reg <= '0;
                    cur_hash_reg <= '0;
                    if (s_fire) begin
                        req_reg <= s_data.req_type;
                        if (s_data.req_type == REQ_CLEAR) begin
                            count_reg <= '0;
                            clr_addr_reg <= '0;
                            state_reg <= S_CLEAR;
                        end else if (s_data.req_type != REQ_PLANE && s_data.last) begin
                            state_reg <= S_HASH_RD;
                        end
                    end
                end
                S_HASH_RD: begin
                    state_reg <= S_HASH_ACC;
                end
                S_HASH_ACC: begin
                    dim_reg <= dim_reg + 1'b1;
                    state_reg <= (dim_reg == (DimW + 1)'(Dim - 1)) ? S_HASH_END : S_HASH_RD;
                end
                S_HASH_END: begin
                    dim_reg <= '0;
                    if ((BitW + 1)'(bit_reg) == nbits - 1'b1) begin
                        hash_reg[tab_reg] <= cur_hash_reg | (HashBits'(!acc[AccW-1]) << bit_reg);
                        cur_hash_reg <= '0;
                        bit_reg <= '0;
                        if ((TabW + 1)'(tab_reg) == ntab - 1'b1) begin
                            tab_reg <= '0;
                            state_reg <= (count_reg == '0) ? S_LINK_RD : S_HEAD_RD;
                        end else begin
                            tab_reg <= tab_reg + 1'b1;
                            state_reg <= S_HASH_RD;
                        end
                    end else begin
                        cur_hash_reg <= cur_hash_reg | (HashBits'(!acc[AccW-1]) << bit_reg);
                        bit_reg <= bit_reg + 1'b1;
                        state_reg <= S_HASH_RD;
                    end
                end
                S_HEAD_RD: begin
                    steps_reg <= '0;
                    state_reg <= S_HEAD_WAIT;
                end
                S_HEAD_WAIT: begin
                    ptr_reg <= head_rd_reg;
                    dim_reg <= '0;
                    state_reg <= S_LINK_RD;
                    if (head_rd_reg != '0) begin
                        state_reg <= S_DIST_RD;
                    end
                end
                S_DIST_RD: begin
                    if (steps_reg > count_reg || ptr_reg > CntW'(MaxVectors)) begin
                        state_reg <= S_LINK_RD;
                    end else begin
                        state_reg <= S_DIST_ACC;
                    end
                end
                S_DIST_ACC: begin
                    dim_reg <= dim_reg + 1'b1;
                    state_reg <= (dim_reg == (DimW + 1)'(Dim - 1)) ? S_DIST_END : S_DIST_RD;
                end
                S_DIST_END: begin
                    dim_reg <= '0;
                    steps_reg <= steps_reg + 1'b1;
                    if (ptr_reg <= count_reg && acc <= AccW'(eps_reg)) begin
                        out_status_reg <= ST_DUPLICATE;
                        out_index_reg <= idx;
                        state_reg <= S_OUT;
                    end else begin
                        ptr_reg <= link_rd_reg;
                        state_reg <= (link_rd_reg != '0) ? S_DIST_RD : S_LINK_RD;
                    end
                end
                S_LINK_RD: begin
                    // Entered at the end of a chain, or straight after hashing when the store is empty.
                    if (count_reg != '0 && (TabW + 1)'(tab_reg) != ntab - 1'b1) begin
                        tab_reg <= tab_reg + 1'b1;
                        state_reg <= S_HEAD_RD;
                    end else if (req_reg == REQ_CHECK) begin
                        out_status_reg <= ST_NO_MATCH;
                        out_index_reg <= '0;
                        state_reg <= S_OUT;
                    end else if (count_reg == CntW'(MaxVectors)) begin
                        out_status_reg <= ST_FULL;
                        out_index_reg <= '0;
                        state_reg <= S_OUT;
                    end else begin
                        tab_reg <= '0;
                        dim_reg <= '0;
                        state_reg <= S_INS_WR;
                    end
                end
                S_INS_WR: begin
                    dim_reg <= dim_reg + 1'b1;
                    if (dim_reg == (DimW + 1)'(Dim)) begin
                        out_status_reg <= ST_INSERTED;
                        out_index_reg <= count_reg[VecW-1:0];
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_INS_RD;
                    end
                end
                S_INS_RD: begin
                    state_reg <= S_INS_LINK;
                end
                S_INS_LINK: begin
                    if ((TabW + 1)'(tab_reg) == ntab - 1'b1) begin
                        state_reg <= S_OUT;
                    end else begin
                        tab_reg <= tab_reg + 1'b1;
                        state_reg <= S_INS_RD;
                    end
                end
                S_OUT: begin
                    m_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(MaxVectors)) else $error("count overflow");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result dropped");
`endif
endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the near-duplicate index unit.
`timescale 1ns / 1ps
module tb;
    import lsh_pkg::*;

    localparam int WatchdogLimit = 1500000;
    localparam int ClearCycles = 34000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = CFG_EPSILON;
    logic [35:0] cfg_data = '0;

    lsh_near_duplicate_index_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    // Predicted state of the index.
    shortint plane_mem[NumTables][HashBits][Dim];
    shortint vec_mem[MaxVectors][Dim];
    int unsigned head_mem[NumTables][1 << HashBits];
    int unsigned link_mem[MaxVectors][NumTables];
    int unsigned n_stored = 0;
    shortint query_mem[Dim];
    logic [35:0] eps_reg = '0;
    logic [3:0] tables_reg = 4'd8;
    logic [3:0] bits_reg = 4'd12;

    out_item_t lookup_q[$];
    int errors = 0;
    bit no_idle = 1'b0;
    bit last_was_clear = 1'b0;
    int stall_left = 0;
    int idle_cycles = 0;

    function automatic longint unsigned dist_to(int unsigned idx);
        longint unsigned sum;
        longint diff;
        sum = 0;
        for (int d = 0; d < Dim; d++) begin
            diff = longint'(query_mem[d]) - longint'(vec_mem[idx][d]);
            sum += longint'(diff * diff);
        end
        return sum;
    endfunction

    function automatic void predict_lookup(in_item_t it);
        int unsigned nt, nb, ptr, steps, idx, hit;
        int unsigned hashes[NumTables];
        longint acc;
        bit found;
        out_item_t res;
        if (it.req_type == REQ_PLANE) begin
            if (it.plane_bit < HashBits)
                plane_mem[it.plane_table][it.plane_bit][it.element_index] = it.value;
            return;
        end
        if (it.req_type == REQ_CLEAR) begin
            foreach (head_mem[t, h]) head_mem[t][h] = 0;
            n_stored = 0;
            return;
        end
        query_mem[it.element_index] = it.value;
        if (!it.last) return;
        nt = (tables_reg == 0 || tables_reg > NumTables) ? NumTables : tables_reg;
        nb = (bits_reg == 0 || bits_reg > HashBits) ? HashBits : bits_reg;
        for (int t = 0; t < nt; t++) begin
            hashes[t] = 0;
            for (int b = 0; b < nb; b++) begin
                acc = 0;
                for (int d = 0; d < Dim; d++)
                    acc += longint'(query_mem[d]) * longint'(plane_mem[t][b][d]);
                if (acc >= 0) hashes[t] |= (1 << b);
            end
        end
        found = 1'b0;
        hit = 0;
        if (n_stored != 0) begin
            for (int t = 0; t < nt && !found; t++) begin
                ptr = head_mem[t][hashes[t]];
                steps = 0;
                while (ptr != 0 && steps <= n_stored && !found) begin
                    idx = ptr - 1;
                    steps++;
                    if (idx >= MaxVectors) break;
                    if (idx < n_stored && dist_to(idx) <= longint'(eps_reg)) begin
                        found = 1'b1;
                        hit = idx;
                    end else begin
                        ptr = link_mem[idx][t];
                    end
                end
            end
        end
        res.match_index = '0;
        if (found) begin
            res.status = ST_DUPLICATE;
            res.match_index = hit[9:0];
        end else if (it.req_type == REQ_CHECK) begin
            res.status = ST_NO_MATCH;
        end else if (n_stored >= MaxVectors) begin
            res.status = ST_FULL;
        end else begin
            for (int d = 0; d < Dim; d++) vec_mem[n_stored][d] = query_mem[d];
            for (int t = 0; t < nt; t++) begin
                link_mem[n_stored][t] = head_mem[t][hashes[t]];
                head_mem[t][hashes[t]] = n_stored + 1;
            end
            res.status = ST_INSERTED;
            res.match_index = n_stored[9:0];
            n_stored++;
        end
        res.stored_count = n_stored[10:0];
        lookup_q.push_back(res);
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic shortint pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return -16'sd32768;
        if (r == 1) return 16'sd32767;
        if (r == 2) return 16'sd0;
        return shortint'($urandom());
    endfunction

    function automatic in_item_t mk(req_type_t req, shortint val, int tab, int pbit,
                                    int idx, bit lst);
        in_item_t it;
        it.req_type = req;
        it.value = val;
        it.plane_table = tab[2:0];
        it.plane_bit = pbit[3:0];
        it.element_index = idx[3:0];
        it.last = lst;
        return it;
    endfunction

    task automatic send_request(in_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        predict_lookup(it);
        last_was_clear = (it.req_type == REQ_CLEAR);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (lookup_q.size() != 0) @(posedge aclk);
        repeat (last_was_clear ? ClearCycles : 60) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [35:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_EPSILON: eps_reg = data;
            CFG_TABLES: tables_reg = data[3:0];
            CFG_BITS: bits_reg = data[3:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [35:0] eps, logic [3:0] tabs, logic [3:0] nbits);
        drain();
        write_reg(CFG_EPSILON, eps);
        write_reg(CFG_TABLES, {32'd0, tabs});
        write_reg(CFG_BITS, {32'd0, nbits});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_full_vector(req_type_t req, shortint base, bit extreme);
        for (int d = 0; d < Dim; d++)
            send_request(mk(req,
                            extreme ? base : shortint'(base + d * 97),
                            $urandom_range(0, 7), $urandom_range(0, 15), d, d == Dim - 1));
    endtask

    task automatic send_near_copy(req_type_t req);
        int idx, v;
        idx = $urandom_range(0, n_stored - 1);
        for (int d = 0; d < Dim; d++) begin
            v = vec_mem[idx][d] + $urandom_range(0, 6) - 3;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            send_request(mk(req, shortint'(v), 0, 0, d, d == Dim - 1));
        end
    endtask

    task automatic load_planes();
        for (int t = 0; t < NumTables; t++)
            for (int b = 0; b < HashBits; b++)
                for (int d = 0; d < Dim; d++)
                    send_request(mk(REQ_PLANE, pick_value(), t, b, d, $urandom_range(0, 1)));
        for (int b = HashBits; b < 16; b++)
            send_request(mk(REQ_PLANE, pick_value(), $urandom_range(0, 7), b,
                            $urandom_range(0, 15), 1'b0));
    endtask

    task automatic test_directed_lookup();
        configure(36'd0, 4'd8, 4'd12);
        send_full_vector(REQ_CHECK, 16'sd100, 1'b0);
        send_full_vector(REQ_INSERT, 16'sd100, 1'b0);
        send_full_vector(REQ_INSERT, 16'sd100, 1'b0);
        send_full_vector(REQ_INSERT, -16'sd32768, 1'b1);
        send_full_vector(REQ_CHECK, 16'sd32767, 1'b1);
        send_request(mk(REQ_INSERT, 16'sd32767, 0, 0, 15, 1'b0));
        send_request(mk(REQ_CHECK, 16'sd5, 7, 11, 3, 1'b1));
        send_request(mk(REQ_CHECK, 16'sd6, 0, 0, 3, 1'b0));
        send_request(mk(REQ_INSERT, 16'sd7, 0, 0, 3, 1'b1));
        configure(36'hF_FFFF_FFFF, 4'd8, 4'd12);
        send_request(mk(REQ_CHECK, -16'sd1, 0, 0, 0, 1'b1));
        send_request(mk(REQ_CLEAR, 16'sd0, 0, 0, 0, 1'b0));
        send_request(mk(REQ_CHECK, -16'sd1, 0, 0, 0, 1'b1));
        send_request(mk(REQ_INSERT, 16'sd3, 0, 0, 9, 1'b1));
    endtask

    task automatic test_register_range();
        logic [3:0] odd_vals[6] = '{4'd0, 4'd9, 4'd15, 4'd1, 4'd13, 4'd0};
        for (int k = 0; k < 6; k++) begin
            configure({4'($urandom_range(0, 15)), $urandom()}, odd_vals[k], odd_vals[5 - k]);
            send_request(mk(REQ_INSERT, pick_value(), 0, 0, $urandom_range(0, 15), 1'b1));
            send_request(mk(REQ_CHECK, pick_value(), 0, 0, $urandom_range(0, 15), 1'b1));
        end
    endtask

    task automatic test_store_full();
        configure(36'd0, 4'd1, 4'd12);
        send_request(mk(REQ_CLEAR, 16'sd0, 0, 0, 0, 1'b0));
        no_idle = 1'b1;
        while (n_stored < MaxVectors)
            send_request(mk(REQ_INSERT, shortint'($urandom()), 0, 0,
                            $urandom_range(0, 15), 1'b1));
        no_idle = 1'b0;
        repeat (3)
            send_request(mk(REQ_INSERT, shortint'($urandom()), 0, 0,
                            $urandom_range(0, 15), 1'b1));
        send_request(mk(REQ_CHECK, shortint'($urandom()), 0, 0, 2, 1'b1));
        send_request(mk(REQ_CLEAR, 16'sd0, 0, 0, 0, 1'b0));
    endtask

    task automatic test_random_traffic();
        int sent, r, n;
        logic [35:0] eps;
        sent = 0;
        while (sent < 370) begin
            if ((sent % 70) == 0) begin
                r = $urandom_range(0, 3);
                eps = (r == 0) ? 36'd0 : (r == 1) ? 36'hF_FFFF_FFFF :
                      (r == 2) ? 36'($urandom_range(1, 4096)) :
                      {4'($urandom_range(0, 15)), $urandom()};
                configure(eps, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
                no_idle = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 15 && n_stored != 0) begin
                send_near_copy($urandom_range(0, 1) ? REQ_INSERT : REQ_CHECK);
                sent += Dim;
            end else if (r < 85) begin
                n = $urandom_range(1, 5);
                for (int k = 0; k < n; k++)
                    send_request(mk($urandom_range(0, 1) ? REQ_INSERT : REQ_CHECK,
                                    pick_value(), $urandom_range(0, 7),
                                    $urandom_range(0, 15), $urandom_range(0, 15), k == n - 1));
                sent += n;
            end else if (r < 98 || sent < 150 || sent > 200) begin
                send_request(mk(REQ_PLANE, pick_value(), $urandom_range(0, 7),
                                $urandom_range(0, 15), $urandom_range(0, 15),
                                $urandom_range(0, 1)));
                sent++;
            end else begin
                send_request(mk(REQ_CLEAR, pick_value(), $urandom_range(0, 7),
                                $urandom_range(0, 15), $urandom_range(0, 15),
                                $urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 99) < 20) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                       : $urandom_range(0, 3);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        out_item_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (lookup_q.size() == 0) begin
                $error("result with no request outstanding: %h", m_data);
                errors++;
            end else begin
                exp_res = lookup_q.pop_front();
                if (m_data.status !== exp_res.status) begin
                    $error("status expected %0d actual %0d", exp_res.status, m_data.status);
                    errors++;
                end
                if (m_data.match_index !== exp_res.match_index) begin
                    $error("match_index expected %0d actual %0d",
                           exp_res.match_index, m_data.match_index);
                    errors++;
                end
                if (m_data.stored_count !== exp_res.stored_count) begin
                    $error("stored_count expected %0d actual %0d",
                           exp_res.stored_count, m_data.stored_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        foreach (head_mem[t, h]) head_mem[t][h] = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        last_was_clear = 1'b1;
        load_planes();
        test_directed_lookup();
        test_register_range();
        test_store_full();
        test_random_traffic();
        drain();
        if (lookup_q.size() == 0 && errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
